[rtl/core/assert_macros.svh]
// Assertion macros shared by the quad corner regularity RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define QCR_CHECK(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

// Check that a trigger implies a consequence in the following cycle.
`define QCR_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/qcr_pkg.sv]
// Types, widths and the arctangent table for the quad corner regularity unit.
`timescale 1ns / 1ps
`default_nettype none
package qcr_pkg;

  localparam int COORD_W         = 24;
  localparam int EDGE_W          = COORD_W + 1;
  localparam int PROD_W          = 2 * EDGE_W;
  localparam int DOT_W           = PROD_W + 2;
  localparam int CROSS_W         = PROD_W + 1;
  localparam int MAG_W           = DOT_W;
  localparam int LEN_W           = $clog2(MAG_W + 1);
  localparam int NORM_BITS       = 31;
  localparam int SQ_W            = 2 * NORM_BITS;
  localparam int RAD_W           = SQ_W + 2;
  localparam int ROOT_W          = RAD_W / 2;
  localparam int SQRT_STEPS      = ROOT_W;
  localparam int STEP_W          = 5;
  localparam int TAB_FRAC        = 28;
  localparam int CORDIC_STEPS    = 28;
  localparam int CW              = 36;
  localparam int ZW              = 38;
  localparam int ANG_W           = 36;
  localparam int DEV_W           = 35;
  localparam int SUM4_W          = DEV_W + 2;
  localparam int ANGLE_FRAC_BITS = 16;
  localparam int RND_SHIFT       = TAB_FRAC - ANGLE_FRAC_BITS;
  localparam int OUT_W           = 25;
  localparam int GEOM_LAT        = 8;
  localparam int LANE_LAT        = GEOM_LAT + SQRT_STEPS + CORDIC_STEPS + 1;
  localparam int PIPE_LAT        = LANE_LAT + 1;

  localparam logic [ANG_W-1:0] RIGHT_Q    = ANG_W'(90) << TAB_FRAC;
  localparam logic [ANG_W-1:0] STRAIGHT_Q = ANG_W'(180) << TAB_FRAC;
  localparam logic [OUT_W-1:0] DEV_MAX    = OUT_W'(360 << ANGLE_FRAC_BITS);

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] p0_x;
    logic signed [COORD_W-1:0] p0_y;
    logic signed [COORD_W-1:0] p0_z;
    logic signed [COORD_W-1:0] p1_x;
    logic signed [COORD_W-1:0] p1_y;
    logic signed [COORD_W-1:0] p1_z;
    logic signed [COORD_W-1:0] p2_x;
    logic signed [COORD_W-1:0] p2_y;
    logic signed [COORD_W-1:0] p2_z;
    logic signed [COORD_W-1:0] p3_x;
    logic signed [COORD_W-1:0] p3_y;
    logic signed [COORD_W-1:0] p3_z;
  } in_item_t;

  typedef struct packed {
    logic [OUT_W-1:0] deviation_sum;
    logic             degenerate;
  } out_item_t;

  // Corner classification carried alongside the data
  typedef struct packed {
    logic degen;
    logic crz;
    logic dz;
    logic dneg;
  } flags_t;

  typedef struct packed {
    logic [RAD_W-1:0]     rem;
    logic [ROOT_W-1:0]    root;
    logic [NORM_BITS-1:0] dm;
    flags_t               fl;
  } sqrt_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    flags_t               fl;
  } cordic_t;

  // atan(2^-i) in degrees, Q28, rounded to nearest
  function automatic logic signed [ZW-1:0] atan_q28(input logic [STEP_W-1:0] i);
    unique case (i)
      5'd0:    atan_q28 = ZW'(64'd12079595520);
      5'd1:    atan_q28 = ZW'(64'd7131001626);
      5'd2:    atan_q28 = ZW'(64'd3767825416);
      5'd3:    atan_q28 = ZW'(64'd1912607013);
      5'd4:    atan_q28 = ZW'(64'd960014949);
      5'd5:    atan_q28 = ZW'(64'd480475470);
      5'd6:    atan_q28 = ZW'(64'd240296363);
      5'd7:    atan_q28 = ZW'(64'd120155514);
      5'd8:    atan_q28 = ZW'(64'd60078674);
      5'd9:    atan_q28 = ZW'(64'd30039451);
      5'd10:   atan_q28 = ZW'(64'd15019740);
      5'd11:   atan_q28 = ZW'(64'd7509872);
      5'd12:   atan_q28 = ZW'(64'd3754936);
      5'd13:   atan_q28 = ZW'(64'd1877468);
      5'd14:   atan_q28 = ZW'(64'd938734);
      5'd15:   atan_q28 = ZW'(64'd469367);
      5'd16:   atan_q28 = ZW'(64'd234684);
      5'd17:   atan_q28 = ZW'(64'd117342);
      5'd18:   atan_q28 = ZW'(64'd58671);
      5'd19:   atan_q28 = ZW'(64'd29335);
      5'd20:   atan_q28 = ZW'(64'd14668);
      5'd21:   atan_q28 = ZW'(64'd7334);
      5'd22:   atan_q28 = ZW'(64'd3667);
      5'd23:   atan_q28 = ZW'(64'd1833);
      5'd24:   atan_q28 = ZW'(64'd917);
      5'd25:   atan_q28 = ZW'(64'd458);
      5'd26:   atan_q28 = ZW'(64'd229);
      5'd27:   atan_q28 = ZW'(64'd115);
      default: atan_q28 = '0;
    endcase
  endfunction

endpackage
`default_nettype wire

[rtl/core/qcr_geom.sv]
// Corner geometry front end: edges, dot and cross products, normalize, radicand.
`timescale 1ns / 1ps
`default_nettype none
module qcr_geom (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire qcr_pkg::point_t pa,
  input  wire qcr_pkg::point_t pb,
  input  wire qcr_pkg::point_t pc,
  output qcr_pkg::sqrt_t      sq_o
);
  import qcr_pkg::*;

  logic signed [EDGE_W-1:0]  e0_r [3];
  logic signed [EDGE_W-1:0]  e1_r [3];
  logic signed [PROD_W-1:0]  pr_r [9];
  logic                      degen2_r, degen3_r;
  logic signed [DOT_W-1:0]   d_r;
  logic signed [CROSS_W-1:0] cr_r [3];
  logic [MAG_W-1:0]          dm4_r, dm5_r;
  logic [MAG_W-1:0]          cm4_r [3];
  logic [MAG_W-1:0]          cm5_r [3];
  flags_t                    fl4_r, fl5_r, fl6_r, fl7_r;
  logic [LEN_W-1:0]          len5_r;
  logic [MAG_W-1:0]          orv;
  logic [LEN_W-1:0]          len;
  logic [NORM_BITS-1:0]      dm6_r, dm7_r;
  logic [NORM_BITS-1:0]      cm6_r [3];
  logic [SQ_W-1:0]           sq7_r [3];

  function automatic logic [NORM_BITS-1:0] norm_mag(input logic [MAG_W-1:0] v,
                                                     input logic [LEN_W-1:0] l);
    if (l > LEN_W'(NORM_BITS)) begin
      norm_mag = NORM_BITS'(v >> (l - LEN_W'(NORM_BITS)));
    end else begin
      norm_mag = NORM_BITS'(v << (LEN_W'(NORM_BITS) - l));
    end
  endfunction

  // Bit length of the largest magnitude equals that of their OR; take it from
  // the same beat that advances into the next stage
  always_comb begin
    orv = dm4_r | cm4_r[0] | cm4_r[1] | cm4_r[2];
    len = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (orv[i]) len = LEN_W'(i + 1);
    end
  end

  // Edges of 25 bits are used as they are, with no edge scaling
  always_ff @(posedge clk) begin
    if (en) begin
      e0_r[0] <= EDGE_W'(pa.x) - EDGE_W'(pb.x);
      e0_r[1] <= EDGE_W'(pa.y) - EDGE_W'(pb.y);
      e0_r[2] <= EDGE_W'(pa.z) - EDGE_W'(pb.z);
      e1_r[0] <= EDGE_W'(pc.x) - EDGE_W'(pb.x);
      e1_r[1] <= EDGE_W'(pc.y) - EDGE_W'(pb.y);
      e1_r[2] <= EDGE_W'(pc.z) - EDGE_W'(pb.z);

      pr_r[0]  <= e0_r[0] * e1_r[0];
      pr_r[1]  <= e0_r[1] * e1_r[1];
      pr_r[2]  <= e0_r[2] * e1_r[2];
      pr_r[3]  <= e0_r[1] * e1_r[2];
      pr_r[4]  <= e0_r[2] * e1_r[1];
      pr_r[5]  <= e0_r[2] * e1_r[0];
      pr_r[6]  <= e0_r[0] * e1_r[2];
      pr_r[7]  <= e0_r[0] * e1_r[1];
      pr_r[8]  <= e0_r[1] * e1_r[0];
      degen2_r <= (e0_r[0] == '0 && e0_r[1] == '0 && e0_r[2] == '0) ||
                  (e1_r[0] == '0 && e1_r[1] == '0 && e1_r[2] == '0);

      d_r      <= DOT_W'(pr_r[0]) + DOT_W'(pr_r[1]) + DOT_W'(pr_r[2]);
      cr_r[0]  <= CROSS_W'(pr_r[3]) - CROSS_W'(pr_r[4]);
      cr_r[1]  <= CROSS_W'(pr_r[5]) - CROSS_W'(pr_r[6]);
      cr_r[2]  <= CROSS_W'(pr_r[7]) - CROSS_W'(pr_r[8]);
      degen3_r <= degen2_r;

      dm4_r      <= d_r[DOT_W-1] ? MAG_W'(-d_r) : MAG_W'(d_r);
      for (int j = 0; j < 3; j++) begin
        cm4_r[j] <= cr_r[j][CROSS_W-1] ? MAG_W'(-cr_r[j]) : MAG_W'(cr_r[j]);
      end
      fl4_r.degen <= degen3_r;
      fl4_r.crz   <= (cr_r[0] == '0) && (cr_r[1] == '0) && (cr_r[2] == '0);
      fl4_r.dz    <= (d_r == '0);
      fl4_r.dneg  <= d_r[DOT_W-1];

      dm5_r  <= dm4_r;
      cm5_r  <= cm4_r;
      fl5_r  <= fl4_r;
      len5_r <= len;

      dm6_r <= norm_mag(dm5_r, len5_r);
      for (int j = 0; j < 3; j++) begin
        cm6_r[j] <= norm_mag(cm5_r[j], len5_r);
      end
      fl6_r <= fl5_r;

      for (int j = 0; j < 3; j++) begin
        sq7_r[j] <= SQ_W'(cm6_r[j]) * SQ_W'(cm6_r[j]);
      end
      dm7_r <= dm6_r;
      fl7_r <= fl6_r;

      sq_o.rem  <= RAD_W'(sq7_r[0]) + RAD_W'(sq7_r[1]) + RAD_W'(sq7_r[2]);
      sq_o.root <= '0;
      sq_o.dm   <= dm7_r;
      sq_o.fl   <= fl7_r;
    end
  end

endmodule
`default_nettype wire

[rtl/core/qcr_sqrt_cell.sv]
// One bit of the restoring integer square root chain.
`timescale 1ns / 1ps
`default_nettype none
module qcr_sqrt_cell (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic [qcr_pkg::STEP_W-1:0] step,
  input  wire qcr_pkg::sqrt_t           d_i,
  output qcr_pkg::sqrt_t                d_o
);
  import qcr_pkg::*;

  logic [RAD_W:0] trial;
  sqrt_t          nxt;

  // trial = (root + 2^b)^2 - root^2
  always_comb begin
    trial = ((RAD_W + 1)'(d_i.root) << (step + 1)) + ((RAD_W + 1)'(1) << (2 * step));
    nxt   = d_i;
    if ({1'b0, d_i.rem} >= trial) begin
      nxt.rem  = d_i.rem - trial[RAD_W-1:0];
      nxt.root = d_i.root | (ROOT_W'(1) << step);
    end
  end

  always_ff @(posedge clk) begin
    if (en) d_o <= nxt;
  end

endmodule
`default_nettype wire

[rtl/core/qcr_cordic_cell.sv]
// One vectoring rotation of the arctangent chain.
`timescale 1ns / 1ps
`default_nettype none
module qcr_cordic_cell (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic [qcr_pkg::STEP_W-1:0] step,
  input  wire qcr_pkg::cordic_t         d_i,
  output qcr_pkg::cordic_t              d_o
);
  import qcr_pkg::*;

  logic signed [CW-1:0] dx, dy;
  cordic_t              nxt;

  // Shift right with the magnitude truncated toward zero
  function automatic logic signed [CW-1:0] shr_tz(input logic signed [CW-1:0] v,
                                                  input logic [STEP_W-1:0] s);
    logic signed [CW-1:0] m;
    m = v[CW-1] ? -v : v;
    m = m >>> s;
    return v[CW-1] ? -m : m;
  endfunction

  always_comb begin
    dx     = shr_tz(d_i.y, step);
    dy     = shr_tz(d_i.x, step);
    nxt.fl = d_i.fl;
    if (!d_i.y[CW-1]) begin
      nxt.x = d_i.x + dx;
      nxt.y = d_i.y - dy;
      nxt.z = d_i.z + atan_q28(step);
    end else begin
      nxt.x = d_i.x - dx;
      nxt.y = d_i.y + dy;
      nxt.z = d_i.z - atan_q28(step);
    end
  end

  always_ff @(posedge clk) begin
    if (en) d_o <= nxt;
  end

endmodule
`default_nettype wire

[rtl/core/qcr_lane.sv]
// One corner lane: geometry, square-root chain, CORDIC chain, deviation.
`timescale 1ns / 1ps
`default_nettype none
module qcr_lane (
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire qcr_pkg::point_t         pa,
  input  wire qcr_pkg::point_t         pb,
  input  wire qcr_pkg::point_t         pc,
  output logic [qcr_pkg::DEV_W-1:0]    dev_o,
  output logic                         degen_o
);
  import qcr_pkg::*;

  sqrt_t             sq [SQRT_STEPS+1];
  cordic_t           co [CORDIC_STEPS+1];
  logic [ANG_W-1:0]  zc, ang;
  logic [DEV_W-1:0]  dev;
  flags_t            fl;

  qcr_geom u_geom (
    .clk  (clk),
    .en   (en),
    .pa   (pa),
    .pb   (pb),
    .pc   (pc),
    .sq_o (sq[0])
  );

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    qcr_sqrt_cell u_cell (
      .clk  (clk),
      .en   (en),
      .step (STEP_W'(SQRT_STEPS - 1 - k)),
      .d_i  (sq[k]),
      .d_o  (sq[k+1])
    );
  end

  // Start vectoring at x = |d|, y = |c|
  assign co[0].x  = CW'(sq[SQRT_STEPS].dm);
  assign co[0].y  = CW'(sq[SQRT_STEPS].root);
  assign co[0].z  = '0;
  assign co[0].fl = sq[SQRT_STEPS].fl;

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
    qcr_cordic_cell u_cell (
      .clk  (clk),
      .en   (en),
      .step (STEP_W'(k)),
      .d_i  (co[k]),
      .d_o  (co[k+1])
    );
  end

  always_comb begin
    fl = co[CORDIC_STEPS].fl;
    if (co[CORDIC_STEPS].z[ZW-1]) begin
      zc = '0;
    end else if (co[CORDIC_STEPS].z[ZW-1:0] > ZW'(RIGHT_Q)) begin
      zc = RIGHT_Q;
    end else begin
      zc = ANG_W'(co[CORDIC_STEPS].z);
    end
    priority if (fl.crz) begin
      ang = fl.dneg ? STRAIGHT_Q : '0;
    end else if (fl.dz) begin
      ang = RIGHT_Q;
    end else begin
      ang = fl.dneg ? STRAIGHT_Q - zc : zc;
    end
    dev = (ang >= RIGHT_Q) ? DEV_W'(ang - RIGHT_Q) : DEV_W'(RIGHT_Q - ang);
    if (fl.degen) dev = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dev_o   <= dev;
      degen_o <= fl.degen;
    end
  end

endmodule
`default_nettype wire

[rtl/core/quad_corner_regularity_unit.sv]
// Top level of the quad corner regularity unit: four corner lanes, sum, output skid.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// Takes the four corners of a quad (signed 24-bit x, y, z each) and returns the
// sum over the corners of |interior angle - 90 degrees| as unsigned Q9.16
// degrees, plus a flag that is set when any corner has a zero-length edge (such
// a corner adds nothing). Each corner runs in its own lane: edge vectors, dot
// and cross products, a common normalizing shift to 31 bits, a 32-cell
// square-root chain for the cross-product length, then a 28-cell vectoring
// CORDIC chain for atan2 and a final clamp/deviation stage. The lane results
// are added and rounded once. One quad is accepted per cycle while in_stall is
// low; each result passes through the 70 pipeline stages and then the output
// register. All stages advance together; the output register and a one-beat
// skid behind it let the pipeline keep accepting while a result waits, and
// in_stall rises only once the skid holds a beat.
module quad_corner_regularity_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire qcr_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output qcr_pkg::out_item_t      out_data
);
  import qcr_pkg::*;

  point_t               pt  [4];
  logic [DEV_W-1:0]     dev [4];
  logic [3:0]           dgn;
  logic                 advance, accept;
  logic [PIPE_LAT-1:0]  v_r;
  logic [SUM4_W-1:0]    sum_r;
  logic                 sdeg_r;
  logic [SUM4_W:0]      rnd, shifted;
  out_item_t            p_data;
  logic                 p_valid;

  logic                 out_valid_r, out_valid_nxt;
  logic                 skid_valid_r, skid_valid_nxt;
  out_item_t            out_data_r, out_data_nxt;
  out_item_t            skid_data_r;

  assign pt[0] = '{x: in_data.p0_x, y: in_data.p0_y, z: in_data.p0_z};
  assign pt[1] = '{x: in_data.p1_x, y: in_data.p1_y, z: in_data.p1_z};
  assign pt[2] = '{x: in_data.p2_x, y: in_data.p2_y, z: in_data.p2_z};
  assign pt[3] = '{x: in_data.p3_x, y: in_data.p3_y, z: in_data.p3_z};

  // Hold the whole pipeline only while the skid beat is occupied
  assign advance  = !skid_valid_r;
  assign in_stall = skid_valid_r;
  assign accept   = in_valid && !in_stall;

  // Corner k sits between corners k-1 and k+1
  for (genvar k = 0; k < 4; k++) begin : g_lane
    qcr_lane u_lane (
      .clk     (clk),
      .en      (advance),
      .pa      (pt[(k + 3) & 3]),
      .pb      (pt[k]),
      .pc      (pt[(k + 1) & 3]),
      .dev_o   (dev[k]),
      .degen_o (dgn[k])
    );
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sum_r  <= SUM4_W'(dev[0]) + SUM4_W'(dev[1]) + SUM4_W'(dev[2]) + SUM4_W'(dev[3]);
      sdeg_r <= |dgn;
    end
  end

  // Round half up to the output fraction, saturate at all ones
  always_comb begin
    rnd     = (SUM4_W + 1)'(sum_r) + ((SUM4_W + 1)'(1) << (RND_SHIFT - 1));
    shifted = rnd >> RND_SHIFT;
    p_data.degenerate = sdeg_r;
    if (shifted > (SUM4_W + 1)'({OUT_W{1'b1}})) begin
      p_data.deviation_sum = {OUT_W{1'b1}};
    end else begin
      p_data.deviation_sum = OUT_W'(shifted);
    end
  end

  assign p_valid = v_r[PIPE_LAT-1];

  // Output register and skid: drain skid first, catch a beat when output is held
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    if (!out_valid_r || !out_stall) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = p_valid;
        out_data_nxt  = p_data;
      end
    end else if (advance && p_valid) begin
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r          <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (advance) v_r <= {v_r[PIPE_LAT-2:0], accept};
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (advance) skid_data_r <= p_data;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `QCR_CHECK(a_skid_behind_out, !skid_valid_r || out_valid_r, "skid holds a beat while output is empty")
  `QCR_NEXT(a_skid_catch, out_valid_r && out_stall && p_valid && !skid_valid_r, skid_valid_r, "held output lost an arriving beat")
  `QCR_CHECK(a_sum_range, !out_valid_r || (out_data_r.deviation_sum <= DEV_MAX), "deviation sum above four right angles")

endmodule
`default_nettype wire
